@@ rtl/i2cmra_pkg.sv @@
// Package for the I2C master register access block: sequence step kinds,
// the sequence program tables and shared constants. No dependencies.
package i2cmra_pkg;

  localparam int unsigned DelayW = 16;
  localparam logic [DelayW-1:0] DelayReset = 16'd16;
  localparam logic [5:0] StepIdle = 6'd63;
  localparam logic [3:0] RecoveryPulses = 4'd9;
  localparam logic [3:0] BitsPerByte = 4'd8;

  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpRead = 2'd1;
  localparam logic [1:0] OpWrite = 2'd2;
  localparam logic [1:0] OpRecover = 2'd3;

  typedef enum logic [3:0] {
    KStart,
    KStop,
    KSclLow,
    KPulse,
    KWaddrW,
    KWreg,
    KWaddrR,
    KWval,
    KRbyte
  } kind_e;

  function automatic kind_e prog_kind(input logic [1:0] op, input logic [2:0] macro);
    kind_e k;
    k = KStop;
    case (op)
      OpRead: begin
        case (macro)
          3'd0: k = KStart;
          3'd1: k = KWaddrW;
          3'd2: k = KWreg;
          3'd3: k = KStart;
          3'd4: k = KWaddrR;
          3'd5: k = KRbyte;
          default: k = KStop;
        endcase
      end
      OpWrite: begin
        case (macro)
          3'd0: k = KStart;
          3'd1: k = KWaddrW;
          3'd2: k = KWreg;
          3'd3: k = KWval;
          default: k = KStop;
        endcase
      end
      OpRecover: begin
        case (macro)
          3'd0: k = KStop;
          3'd1: k = KSclLow;
          3'd2: k = KStart;
          3'd3: k = KSclLow;
          3'd4: k = KPulse;
          3'd5: k = KStart;
          3'd6: k = KSclLow;
          default: k = KStop;
        endcase
      end
      default: k = KStop;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] prog_len(input logic [1:0] op);
    logic [3:0] n;
    case (op)
      OpRead: n = 4'd7;
      OpWrite: n = 4'd5;
      OpRecover: n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] micro_count(input kind_e k);
    logic [3:0] n;
    case (k)
      KStart: n = 4'd2;
      KStop: n = 4'd3;
      KSclLow: n = 4'd1;
      KPulse: n = 4'd2;
      default: n = 4'd7;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/i2c_master_register_access.sv @@
// Top level of the I2C master register access block: sequencer, prescaler
// and a two-entry result buffer. Depends on i2cmra_pkg.
// A request's result is registered into the output register, or into the skid
// entry if the output is stalled. One request per cycle while s_axis_tready is
// high; the sequencer and prescaler update in a single pass per request. The skid
// stage keeps s_axis_tready high for one stalled result. Reset is asynchronous and
// returns the sequencer to idle with both pins released and delay_ticks 16.
module i2c_master_register_access (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // delay_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // dev_addr, reg_no, wr_value, sda_in, zero fill
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // scl_out, sda_out, busy_res, done_res, nack,
                                      // read_data, zero fill
);
  import i2cmra_pkg::*;

  logic [DelayW-1:0] delay_q;
  logic [5:0]  step_q, step_d;
  logic [3:0]  bc_q, bc_d;
  logic [7:0]  shift_q, shift_d;
  logic [DelayW-1:0] presc_q, presc_d, presc_inc, period;
  logic [1:0]  op_q, op_d;
  logic [7:0]  addr_q, addr_d, reg_q, reg_d, val_q, val_d;
  logic        nack_q, nack_d, scl_q, scl_d, sda_q, sda_d;
  logic        done_c;

  logic        ent;
  logic [2:0]  ent_macro, ent_micro;
  logic [2:0]  cur_macro, cur_micro;
  kind_e       cur_kind, ent_kind;
  logic [3:0]  bc_inc, len;
  logic [7:0]  tx_byte;

  logic        accept;
  logic [1:0]  in_op;
  logic        in_sda;
  logic [12:0] res_c;
  logic [12:0] out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_op = s_axis_tuser;
  assign in_sda = s_axis_tdata[24];
  assign period = (delay_q == '0) ? {{(DelayW-1){1'b0}}, 1'b1} : delay_q;
  assign presc_inc = presc_q + {{(DelayW-1){1'b0}}, 1'b1};
  assign cur_macro = step_q[5:3];
  assign cur_micro = step_q[2:0];
  assign cur_kind = prog_kind(op_q, cur_macro);
  assign bc_inc = bc_q + 4'd1;
  assign len = prog_len(op_q);

  always_comb begin
    step_d = step_q;
    bc_d = bc_q;
    shift_d = shift_q;
    presc_d = presc_q;
    op_d = op_q;
    addr_d = addr_q;
    reg_d = reg_q;
    val_d = val_q;
    nack_d = nack_q;
    scl_d = scl_q;
    sda_d = sda_q;
    done_c = 1'b0;
    ent = 1'b0;
    ent_macro = 3'd0;
    ent_micro = 3'd0;
    if (accept) begin
      if (step_q == StepIdle) begin
        if (in_op != OpTick) begin
          op_d = in_op;
          addr_d = s_axis_tdata[7:0];
          reg_d = s_axis_tdata[15:8];
          val_d = s_axis_tdata[23:16];
          if (in_op == OpRead) begin
            shift_d = 8'd0;
          end
          bc_d = 4'd0;
          presc_d = '0;
          ent = 1'b1;
        end
      end else if (in_op == OpTick) begin
        if (presc_inc >= period) begin
          presc_d = '0;
          if ({1'b0, cur_macro} >= len) begin
            step_d = StepIdle;
            done_c = 1'b1;
          end else if (cur_kind == KPulse && cur_micro == 3'd1) begin
            if (bc_inc < RecoveryPulses) begin
              bc_d = bc_inc;
              ent = 1'b1;
              ent_macro = cur_macro;
            end else begin
              bc_d = 4'd0;
              if ({1'b0, cur_macro} + 4'd1 < len) begin
                ent = 1'b1;
                ent_macro = cur_macro + 3'd1;
              end else begin
                step_d = StepIdle;
                done_c = 1'b1;
              end
            end
          end else if (cur_kind == KRbyte && cur_micro == 3'd2) begin
            shift_d = {shift_q[6:0], in_sda};
            bc_d = bc_inc;
            ent = 1'b1;
            ent_macro = cur_macro;
            ent_micro = (bc_inc < BitsPerByte) ? 3'd1 : 3'd3;
          end else if (cur_kind inside {[KWaddrW:KWval]} && cur_micro == 3'd2) begin
            bc_d = bc_inc;
            ent = 1'b1;
            ent_macro = cur_macro;
            ent_micro = (bc_inc < BitsPerByte) ? 3'd0 : 3'd3;
          end else if (cur_kind inside {KWaddrW, KWreg, KWaddrR} && cur_micro == 3'd6
                       && nack_q) begin
            bc_d = 4'd0;
            ent = 1'b1;
            ent_macro = 3'(len - 4'd1);
          end else if ({1'b0, cur_micro} + 4'd1 < micro_count(cur_kind)) begin
            ent = 1'b1;
            ent_macro = cur_macro;
            ent_micro = cur_micro + 3'd1;
          end else begin
            bc_d = 4'd0;
            if ({1'b0, cur_macro} + 4'd1 < len) begin
              ent = 1'b1;
              ent_macro = cur_macro + 3'd1;
            end else begin
              step_d = StepIdle;
              done_c = 1'b1;
            end
          end
        end else begin
          presc_d = presc_inc;
        end
      end
    end

    ent_kind = prog_kind(op_d, ent_macro);
    case (ent_kind)
      KWaddrW: tx_byte = addr_d;
      KWreg: tx_byte = reg_d;
      KWaddrR: tx_byte = addr_d | 8'h01;
      default: tx_byte = val_d;
    endcase
    if (ent) begin
      step_d = {ent_macro, ent_micro};
      case (ent_kind)
        KStart: begin
          if (ent_micro == 3'd0) scl_d = 1'b1;
          else sda_d = 1'b0;
        end
        KStop: begin
          if (ent_micro == 3'd1) scl_d = 1'b1;
          else sda_d = (ent_micro == 3'd2);
        end
        KSclLow: scl_d = 1'b0;
        KPulse: scl_d = (ent_micro == 3'd0);
        KRbyte: begin
          if (ent_micro == 3'd0 || ent_micro == 3'd4) sda_d = 1'b1;
          else scl_d = (ent_micro == 3'd2 || ent_micro == 3'd5);
        end
        default: begin
          if (ent_micro == 3'd1) begin
            sda_d = tx_byte[3'd7 - bc_d[2:0]];
          end else if (ent_micro == 3'd4) begin
            sda_d = 1'b1;
          end else if (ent_micro == 3'd6) begin
            nack_d = in_sda;
            sda_d = 1'b1;
            scl_d = 1'b0;
          end else begin
            scl_d = (ent_micro == 3'd2 || ent_micro == 3'd5);
          end
        end
      endcase
    end
  end

  assign res_c = {shift_d, nack_d, done_c, (step_d != StepIdle), sda_d, scl_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
      step_q <= StepIdle;
      bc_q <= 4'd0;
      shift_q <= 8'd0;
      presc_q <= '0;
      op_q <= OpTick;
      addr_q <= 8'd0;
      reg_q <= 8'd0;
      val_q <= 8'd0;
      nack_q <= 1'b0;
      scl_q <= 1'b1;
      sda_q <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        delay_q <= cfg_data_i;
      end
      step_q <= step_d;
      bc_q <= bc_d;
      shift_q <= shift_d;
      presc_q <= presc_d;
      op_q <= op_d;
      addr_q <= addr_d;
      reg_q <= reg_d;
      val_q <= val_d;
      nack_q <= nack_d;
      scl_q <= scl_d;
      sda_q <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res_c;
    end else if (accept) begin
      skid_q <= res_c;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {3'd0, out_q};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_micro_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != StepIdle) |-> (step_q[2:0] != 3'd7))
    else $error("sequencer step out of range");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BitsPerByte)
    else $error("bit counter out of range");

  a_idle_bus_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == StepIdle) |-> (scl_q && sda_q))
    else $error("bus not released while idle");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for i2c_master_register_access: drives command and tick requests,
// predicts every pin and status report and checks each one as it leaves.
// Depends on i2cmra_pkg and the i2c_master_register_access RTL.
module tb;
  import i2cmra_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       nack;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } bus_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;  // dev_addr, reg_no, wr_value, sda_in, zero fill
  logic [1:0]  s_axis_tuser = OpTick; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // scl_out, sda_out, busy_res, done_res, nack,
                                      // read_data, zero fill

  // Predicted bus master state.
  logic [5:0]  bus_step = StepIdle;
  logic [3:0]  bus_bits = 4'd0;
  logic [7:0]  bus_shift = 8'd0;
  logic [15:0] bus_pre = 16'd0;
  logic [1:0]  bus_op = OpTick;
  logic [7:0]  bus_addr = 8'd0;
  logic [7:0]  bus_regn = 8'd0;
  logic [7:0]  bus_val = 8'd0;
  logic        bus_nack = 1'b0;
  logic        bus_scl = 1'b1;
  logic        bus_sda = 1'b1;
  logic        bus_done = 1'b0;
  logic [15:0] bus_delay = DelayReset;

  bus_status_t status_due[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          reports_checked = 0;
  int          seqs_done = 0;
  int          seqs_nacked = 0;
  int          stall_pct = 9;

  i2c_master_register_access dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic kind_e step_kind(input logic [1:0] op, input logic [2:0] macro);
    kind_e k;
    k = KStop;
    if (op == OpRead) begin
      case (macro)
        3'd0, 3'd3: k = KStart;
        3'd1: k = KWaddrW;
        3'd2: k = KWreg;
        3'd4: k = KWaddrR;
        3'd5: k = KRbyte;
        default: k = KStop;
      endcase
    end else if (op == OpWrite) begin
      case (macro)
        3'd0: k = KStart;
        3'd1: k = KWaddrW;
        3'd2: k = KWreg;
        3'd3: k = KWval;
        default: k = KStop;
      endcase
    end else if (op == OpRecover) begin
      case (macro)
        3'd1, 3'd3, 3'd6: k = KSclLow;
        3'd2, 3'd5: k = KStart;
        3'd4: k = KPulse;
        default: k = KStop;
      endcase
    end
    return k;
  endfunction

  function automatic logic [3:0] seq_len(input logic [1:0] op);
    case (op)
      OpRead: return 4'd7;
      OpWrite: return 4'd5;
      OpRecover: return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] micro_len(input kind_e k);
    case (k)
      KStart, KPulse: return 4'd2;
      KStop: return 4'd3;
      KSclLow: return 4'd1;
      default: return 4'd7;
    endcase
  endfunction

  function automatic logic is_tx(input kind_e k);
    return k == KWaddrW || k == KWreg || k == KWaddrR || k == KWval;
  endfunction

  function automatic logic [7:0] tx_byte(input kind_e k);
    case (k)
      KWaddrW: return bus_addr;
      KWreg: return bus_regn;
      KWaddrR: return bus_addr | 8'h01;
      default: return bus_val;
    endcase
  endfunction

  task automatic enter_step(input logic [2:0] macro, input logic [2:0] micro, input logic sda);
    kind_e k;
    logic [7:0] tx;
    k = step_kind(bus_op, macro);
    bus_step = {macro, micro};
    case (k)
      KStart: begin
        if (micro == 3'd0) bus_scl = 1'b1;
        else bus_sda = 1'b0;
      end
      KStop: begin
        if (micro == 3'd1) bus_scl = 1'b1;
        else bus_sda = (micro == 3'd2);
      end
      KSclLow: bus_scl = 1'b0;
      KPulse: bus_scl = (micro == 3'd0);
      KRbyte: begin
        if (micro == 3'd0 || micro == 3'd4) bus_sda = 1'b1;
        else bus_scl = (micro == 3'd2 || micro == 3'd5);
      end
      default: begin
        tx = tx_byte(k);
        if (micro == 3'd1) begin
          bus_sda = tx[3'd7 - bus_bits[2:0]];
        end else if (micro == 3'd4) begin
          bus_sda = 1'b1;
        end else if (micro == 3'd6) begin
          bus_nack = sda;
          bus_sda = 1'b1;
          bus_scl = 1'b0;
        end else begin
          bus_scl = (micro == 3'd2 || micro == 3'd5);
        end
      end
    endcase
  endtask

  task automatic next_macro(input logic [2:0] macro, input logic sda);
    bus_bits = 4'd0;
    if ({1'b0, macro} + 4'd1 < seq_len(bus_op)) begin
      enter_step(macro + 3'd1, 3'd0, sda);
    end else begin
      bus_step = StepIdle;
      bus_done = 1'b1;
    end
  endtask

  task automatic expire_step(input logic sda);
    logic [2:0] macro;
    logic [2:0] micro;
    logic [3:0] len;
    kind_e k;
    macro = bus_step[5:3];
    micro = bus_step[2:0];
    len = seq_len(bus_op);
    k = step_kind(bus_op, macro);
    if ({1'b0, macro} >= len) begin
      bus_step = StepIdle;
      bus_done = 1'b1;
    end else if (k == KPulse && micro == 3'd1) begin
      bus_bits = bus_bits + 4'd1;
      if (bus_bits < RecoveryPulses) enter_step(macro, 3'd0, sda);
      else next_macro(macro, sda);
    end else if (k == KRbyte && micro == 3'd2) begin
      bus_shift = {bus_shift[6:0], sda};
      bus_bits = bus_bits + 4'd1;
      enter_step(macro, (bus_bits < BitsPerByte) ? 3'd1 : 3'd3, sda);
    end else if (is_tx(k) && micro == 3'd2) begin
      bus_bits = bus_bits + 4'd1;
      enter_step(macro, (bus_bits < BitsPerByte) ? 3'd0 : 3'd3, sda);
    end else if (is_tx(k) && micro == 3'd6 && bus_nack && k != KWval) begin
      bus_bits = 4'd0;
      enter_step(len[2:0] - 3'd1, 3'd0, sda);
    end else if ({1'b0, micro} + 4'd1 < micro_len(k)) begin
      enter_step(macro, micro + 3'd1, sda);
    end else begin
      next_macro(macro, sda);
    end
  endtask

  task automatic predict_status(input logic [1:0] op, input logic [7:0] addr,
                                input logic [7:0] regn, input logic [7:0] val,
                                input logic sda);
    bus_status_t r;
    logic [15:0] period;
    period = (bus_delay == 16'd0) ? 16'd1 : bus_delay;
    bus_done = 1'b0;
    if (bus_step == StepIdle) begin
      if (op != OpTick) begin
        bus_op = op;
        bus_addr = addr;
        bus_regn = regn;
        bus_val = val;
        if (op == OpRead) bus_shift = 8'd0;
        bus_bits = 4'd0;
        bus_pre = 16'd0;
        enter_step(3'd0, 3'd0, sda);
      end
    end else if (op == OpTick) begin
      bus_pre = bus_pre + 16'd1;
      if (bus_pre >= period) begin
        bus_pre = 16'd0;
        expire_step(sda);
      end
    end
    r.scl = bus_scl;
    r.sda = bus_sda;
    r.busy = (bus_step != StepIdle);
    r.done = bus_done;
    r.nack = bus_nack;
    r.rdata = bus_shift;
    status_due.push_back(r);
    if (bus_done) begin
      seqs_done++;
      if (bus_nack) seqs_nacked++;
    end
  endtask

  // An acknowledge is due on the next tick: answer it from the nack mask
  // (address, register, read address, value); every other level is random.
  function automatic logic pick_sda(input logic [3:0] nack_mask);
    kind_e k;
    logic [15:0] period;
    period = (bus_delay == 16'd0) ? 16'd1 : bus_delay;
    k = step_kind(bus_op, bus_step[5:3]);
    if (bus_step != StepIdle && bus_step[2:0] == 3'd5 && bus_pre + 16'd1 >= period) begin
      case (k)
        KWaddrW: return nack_mask[0];
        KWreg: return nack_mask[1];
        KWaddrR: return nack_mask[2];
        KWval: return nack_mask[3];
        default: ;
      endcase
    end
    return 1'($urandom_range(1, 0));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] regn, input logic [7:0] val,
                           input logic sda);
    while ($urandom_range(99, 0) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, sda, val, regn, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_status(op, addr, regn, val, sda);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_delay(input logic [15:0] ticks);
    wait_drained();
    cfg_data_i <= ticks;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    bus_delay = ticks;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Ticks the running sequence on; a share of requests are commands that
  // arrive while busy and must be ignored.
  task automatic drive_ticks(input logic [3:0] nack_mask, input int noise_pct,
                             input int max_items);
    int n;
    n = 0;
    while (bus_step != StepIdle && n < max_items) begin
      if ($urandom_range(99, 0) < noise_pct)
        send_item(2'($urandom_range(3, 1)), 8'($urandom_range(255, 0)),
                  8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                  1'($urandom_range(1, 0)));
      else
        send_item(OpTick, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                  8'($urandom_range(255, 0)), pick_sda(nack_mask));
      n++;
    end
  endtask

  task automatic run_sequence(input logic [1:0] op, input logic [7:0] addr,
                              input logic [7:0] regn, input logic [7:0] val,
                              input logic [3:0] nack_mask, input int noise_pct);
    send_item(op, addr, regn, val, 1'($urandom_range(1, 0)));
    drive_ticks(nack_mask, noise_pct, 32'h7fffffff);
  endtask

  task automatic test_idle_ticks();
    send_item(OpTick, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(OpTick, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(OpTick, 8'hA5, 8'h5A, 8'h3C, 1'b1);
  endtask

  // The recovery starts at the delay left by reset and finishes at one tick
  // per interval.
  task automatic test_bus_recovery();
    send_item(OpRecover, 8'h00, 8'h00, 8'h00, 1'b0);
    drive_ticks(4'b0000, 5, 40);
    write_delay(16'd1);
    drive_ticks(4'b0000, 5, 32'h7fffffff);
  endtask

  task automatic test_slow_prescaler();
    write_delay(16'hFFFF);
    send_item(OpWrite, 8'hFF, 8'h00, 8'hFF, 1'b0);
    drive_ticks(4'b0000, 20, 30);
    write_delay(16'h0000);
    drive_ticks(4'b0000, 0, 32'h7fffffff);
  endtask

  task automatic test_register_write();
    write_delay(16'd1);
    run_sequence(OpWrite, 8'h00, 8'hFF, 8'h00, 4'b0000, 0);
    run_sequence(OpWrite, 8'hFE, 8'h81, 8'h7E, 4'b0000, 5);
  endtask

  task automatic test_register_read();
    stall_pct = 0;
    run_sequence(OpRead, 8'h00, 8'hFF, 8'h00, 4'b0000, 0);
    stall_pct = 9;
    run_sequence(OpRead, 8'hFE, 8'h5A, 8'hFF, 4'b0000, 5);
  endtask

  task automatic test_nack_abort();
    write_delay(16'd1);
    run_sequence(OpRead, 8'h42, 8'h10, 8'h00, 4'b0001, 0);
    run_sequence(OpWrite, 8'h42, 8'h11, 8'h99, 4'b0010, 0);
    run_sequence(OpRead, 8'h42, 8'h12, 8'h00, 4'b0100, 0);
    run_sequence(OpWrite, 8'h42, 8'h13, 8'h66, 4'b1000, 0);
    run_sequence(OpRecover, 8'h42, 8'h14, 8'h00, 4'b0000, 0);
  endtask

  task automatic test_random_traffic();
    int nseq;
    logic [3:0] mask;
    nseq = 0;
    while (items_sent < 1050) begin
      if (nseq % 4 == 0) begin
        stall_pct = (nseq == 8) ? 0 : 9;
        case ($urandom_range(7, 0))
          0: write_delay(16'd0);
          1, 2: write_delay(16'd2);
          3: write_delay(16'd3);
          default: write_delay(16'd1);
        endcase
      end
      repeat ($urandom_range(2, 0))
        send_item(OpTick, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                  8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
      mask = 4'b0000;
      for (int i = 0; i < 4; i++) if ($urandom_range(99, 0) < 10) mask[i] = 1'b1;
      run_sequence(2'($urandom_range(3, 1)), 8'($urandom_range(255, 0)),
                   8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), mask, 3);
      nseq++;
    end
    stall_pct = 9;
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);

  always @(posedge clk_i) begin
    bus_status_t got;
    bus_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = bus_status_t'(m_axis_tdata[12:0]);
      if (status_due.size() == 0) begin
        $error("Result arrived with no request outstanding: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = status_due.pop_front();
        reports_checked++;
        if (got.scl !== want.scl) begin
          $error("scl_out: expected %0b, got %0b", want.scl, got.scl);
          err_count++;
        end
        if (got.sda !== want.sda) begin
          $error("sda_out: expected %0b, got %0b", want.sda, got.sda);
          err_count++;
        end
        if (got.busy !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, got.busy);
          err_count++;
        end
        if (got.done !== want.done) begin
          $error("done_res: expected %0b, got %0b", want.done, got.done);
          err_count++;
        end
        if (got.nack !== want.nack) begin
          $error("nack: expected %0b, got %0b", want.nack, got.nack);
          err_count++;
        end
        if (got.rdata !== want.rdata) begin
          $error("read_data: expected %02h, got %02h", want.rdata, got.rdata);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_ticks();
    test_bus_recovery();
    test_slow_prescaler();
    test_register_write();
    test_register_read();
    test_nack_abort();
    test_random_traffic();
    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d results over %0d bus sequences,",
             items_sent, reports_checked, seqs_done);
    $display("%0d of which ended with a nack, across delays from 0 to 65535.", seqs_nacked);
    if (err_count == 0 && status_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/i2cmra_pkg.sv
rtl/i2c_master_register_access.sv
sim/tb.sv
